[rtl/dpvd_pkg.sv]
// dpvd_pkg: shared types, constants and the humidity log table for the dew point core
// no dependencies
package dpvd_pkg;

  localparam int FracBits = 16;
  localparam int AgeW = 20;
  localparam int MacW = 48;
  // numerator and divisor width, and step counter width, of the serial divider
  localparam int NumW = 64;
  localparam int CntW = 7;

  localparam logic [1:0] ModeByte = 2'd0;
  localparam logic [1:0] ModeTick = 2'd1;
  localparam logic [1:0] ModeEval = 2'd2;

  localparam logic [1:0] VerdOpen = 2'd0;
  localparam logic [1:0] VerdClose = 2'd1;
  localparam logic [1:0] VerdNone = 2'd2;

  localparam logic [1:0] RegMacIn = 2'd0;
  localparam logic [1:0] RegMacOut = 2'd1;
  localparam logic [1:0] RegTimeout = 2'd2;
  localparam logic [1:0] RegMargin = 2'd3;

  localparam logic [7:0] HdrByte0 = 8'h1A;
  localparam logic [7:0] HdrByte1 = 8'h18;
  localparam logic [5:0] MinLen = 6'd17;
  localparam logic [AgeW-1:0] AgeStale = '1;

  typedef struct packed {
    logic start;
    logic [NumW-1:0] num;
    logic [NumW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic [NumW-1:0] quo;
  } div_rsp_t;

  // log2 with 30 fraction bits, by repeated squaring, as a function over a constant input
  function automatic logic [63:0] log2_q30(input logic [7:0] h);
    logic [63:0] x;
    logic [63:0] res;
    logic [127:0] sq;
    int p;
    p = 0;
    for (int k = 7; k >= 1; k--) begin
      if (p == 0 && h[k]) p = k;
    end
    x = 64'(h) << (30 - p);
    res = '0;
    for (int i = 0; i < 30; i++) begin
      sq = 128'(x) * 128'(x);
      x = sq[93:30];
      res = res << 1;
      if (x >= 64'h8000_0000) begin
        x = x >> 1;
        res[0] = 1'b1;
      end
    end
    return (64'(p) << 30) | res;
  endfunction

  function automatic logic signed [63:0] ln_q30(input logic [7:0] h);
    logic [127:0] m;
    m = 128'(log2_q30(h)) * 128'(64'd744261118);
    return m[93:30];
  endfunction

  // ln(h/100) rounded to FracBits fraction bits, halves away from zero
  function automatic logic signed [31:0] ln_hum(input logic [7:0] h);
    logic signed [63:0] v;
    logic [63:0] m;
    logic [63:0] q;
    v = ln_q30(h) - ln_q30(8'd100);
    m = v[63] ? 64'(-v) : 64'(v);
    q = (m + (64'd1 << (30 - FracBits - 1))) >> (30 - FracBits);
    return v[63] ? -32'(q) : 32'(q);
  endfunction

  // humidity log table, filled at elaboration
  typedef logic [255:0][31:0] ln_tab_t;

  function automatic ln_tab_t build_ln_tab();
    ln_tab_t t;
    for (int h = 0; h < 256; h++) begin
      t[h] = ln_hum(8'(h));
    end
    return t;
  endfunction

  localparam ln_tab_t LnTab = build_ln_tab();

endpackage

[rtl/dpvd_sdiv.sv]
// dpvd_sdiv: bit-serial unsigned restoring divider, one quotient bit per cycle
// depends on dpvd_pkg
module dpvd_sdiv (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dpvd_pkg::div_req_t  req_i,
  output dpvd_pkg::div_rsp_t  rsp_o
);
  import dpvd_pkg::*;

  logic [NumW-1:0] rem_q, quo_q, den_q;
  logic [CntW-1:0] cnt_q;
  logic busy_q, done_q;
  logic [NumW:0] trial;

  assign trial = {rem_q, quo_q[NumW-1]} - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(NumW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.num;
      den_q <= req_i.den;
    end else if (busy_q) begin
      if (!trial[NumW]) begin
        rem_q <= trial[NumW-1:0];
        quo_q <= {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[NumW-2:0], quo_q[NumW-1]};
        quo_q <= {quo_q[NumW-2:0], 1'b0};
      end
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quo = quo_q;
endmodule

[rtl/dpvd_sensor.sv]
// dpvd_sensor: packet parser, reading store and age counters
// depends on dpvd_pkg
module dpvd_sensor (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          beat_i,
  input  logic [1:0]                    mode_i,
  input  logic [dpvd_pkg::MacW-1:0]     mac_i,
  input  logic [7:0]                    byte_i,
  input  logic                          last_i,
  input  logic [dpvd_pkg::MacW-1:0]     mac_in_i,
  input  logic [dpvd_pkg::MacW-1:0]     mac_out_i,
  input  logic [dpvd_pkg::AgeW-1:0]     timeout_i,
  output logic [15:0]                   temp_in_o,
  output logic [7:0]                    hum_in_o,
  output logic [15:0]                   temp_out_o,
  output logic [7:0]                    hum_out_o,
  output logic                          fresh_o
);
  import dpvd_pkg::*;

  logic [5:0] cnt_q;
  logic hdr_q;
  logic [15:0] ctemp_q, tin_q, tout_q;
  logic [7:0] chum_q, hin_q, hout_q;
  logic [AgeW-1:0] age_in_q, age_out_q;
  logic hdr_d, ok;
  logic [15:0] ctemp_d;
  logic [7:0] chum_d;

  always_comb begin
    hdr_d = hdr_q;
    ctemp_d = ctemp_q;
    chum_d = chum_q;
    case (cnt_q)
      6'd5: hdr_d = (byte_i == HdrByte0);
      6'd6: hdr_d = hdr_q && (byte_i == HdrByte1);
      6'd13: ctemp_d = {byte_i, ctemp_q[7:0]};
      6'd14: ctemp_d = {ctemp_q[15:8], byte_i};
      6'd15: chum_d = byte_i;
      default: ;
    endcase
    ok = (cnt_q >= MinLen - 6'd1) && hdr_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      hdr_q <= 1'b0;
      ctemp_q <= '0;
      chum_q <= '0;
      tin_q <= '0;
      hin_q <= '0;
      tout_q <= '0;
      hout_q <= '0;
      age_in_q <= AgeStale;
      age_out_q <= AgeStale;
    end else if (beat_i) begin
      if (mode_i == ModeByte) begin
        ctemp_q <= ctemp_d;
        chum_q <= chum_d;
        if (last_i) begin
          cnt_q <= '0;
          hdr_q <= 1'b0;
          if (ok && mac_i == mac_in_i) begin
            tin_q <= ctemp_d;
            hin_q <= chum_d;
            age_in_q <= '0;
          end else if (ok && mac_i == mac_out_i) begin
            tout_q <= ctemp_d;
            hout_q <= chum_d;
            age_out_q <= '0;
          end
        end else begin
          hdr_q <= hdr_d;
          cnt_q <= (cnt_q == 6'd63) ? cnt_q : cnt_q + 6'd1;
        end
      end else if (mode_i == ModeTick) begin
        if (age_in_q < timeout_i) age_in_q <= age_in_q + 1'b1;
        if (age_out_q < timeout_i) age_out_q <= age_out_q + 1'b1;
      end
    end
  end

  assign temp_in_o = tin_q;
  assign hum_in_o = hin_q;
  assign temp_out_o = tout_q;
  assign hum_out_o = hout_q;
  assign fresh_o = (age_in_q < timeout_i) && (age_out_q < timeout_i);
endmodule

[rtl/dpvd_dew.sv]
// dpvd_dew: sequencer for both magnus dew points, four serial divisions in turn
// depends on dpvd_pkg, dpvd_sdiv
module dpvd_dew (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [15:0]              temp_in_i,
  input  logic [7:0]               hum_in_i,
  input  logic [15:0]              temp_out_i,
  input  logic [7:0]               hum_out_i,
  input  logic                     fresh_i,
  input  logic [10:0]              margin_i,
  output logic                     done_o,
  output logic [1:0]               verdict_o,
  output logic signed [15:0]       dew_in_o,
  output logic signed [15:0]       dew_out_o,
  output logic                     busy_o
);
  import dpvd_pkg::*;

  typedef enum logic [2:0] {
    StIdle, StTerm, StAlpha, StDew, StNext, StDone
  } state_e;

  state_e st_q;
  logic side_q, valid_q, neg_q, done_q;
  logic signed [47:0] alpha_q;
  logic signed [31:0] lnh_q;
  logic signed [15:0] di_q, de_q;
  logic [1:0] verd_q;
  div_req_t req;
  div_rsp_t rsp;

  logic [15:0] traw;
  logic [7:0] hum;
  logic signed [16:0] t10, tden;
  logic signed [63:0] term_n, term_d, alpha_s, den_s, dew_n;
  logic [63:0] un, ud, qsig;
  logic signed [47:0] alpha_d;
  logic signed [63:0] q64;
  logic signed [15:0] dsat;

  dpvd_sdiv u_div (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(req), .rsp_o(rsp));

  always_comb begin
    traw = side_q ? temp_out_i : temp_in_i;
    hum = side_q ? hum_out_i : hum_in_i;
    t10 = 17'(signed'(traw));
    tden = t10 + 17'sd2377;
    term_n = 64'(t10) * 64'sd1727 <<< FracBits;
    term_d = 64'(tden) * 64'sd100;
    alpha_s = 64'(alpha_q);
    den_s = (64'sd1727 <<< FracBits) - alpha_s * 64'sd100;
    dew_n = alpha_s * 64'sd2377000;
    q64 = neg_q ? -64'(signed'(rsp.quo)) : 64'(signed'(rsp.quo));
    alpha_d = 48'(q64) + 48'(lnh_q);
    if (alpha_d > 48'sh200_0000_0000) alpha_d = 48'sh200_0000_0000;
    if (alpha_d < -48'sh200_0000_0000) alpha_d = -48'sh200_0000_0000;
    if (q64 > 64'sd32767) dsat = 16'sh7fff;
    else if (q64 < -64'sd32768) dsat = 16'sh8000;
    else dsat = 16'(q64);
    un = '0;
    ud = '1;
    case (st_q)
      StTerm: begin
        un = term_n[63] ? 64'(-term_n) : term_n;
        ud = term_d[63] ? 64'(-term_d) : term_d;
      end
      StDew: begin
        un = dew_n[63] ? 64'(-dew_n) : dew_n;
        ud = den_s[63] ? 64'(-den_s) : den_s;
      end
      default: ;
    endcase
    qsig = un + (ud >> 1);
    req.num = qsig;
    req.den = ud;
  end

  // division kick: one cycle in StTerm or StDew with divider idle and not just done
  logic kick_q;
  assign req.start = kick_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      side_q <= 1'b0;
      valid_q <= 1'b0;
      kick_q <= 1'b0;
      done_q <= 1'b0;
      neg_q <= 1'b0;
      verd_q <= VerdNone;
      di_q <= '0;
      de_q <= '0;
      alpha_q <= '0;
      lnh_q <= '0;
    end else begin
      kick_q <= 1'b0;
      done_q <= 1'b0;
      case (st_q)
        StIdle: if (start_i) begin
          side_q <= 1'b0;
          valid_q <= fresh_i;
          st_q <= StTerm;
          kick_q <= 1'b1;
        end
        StTerm: begin
          if (!kick_q && !rsp.busy && !rsp.done) begin
            if (hum == 8'd0 || tden == 17'sd0) valid_q <= 1'b0;
            neg_q <= term_n[63] ^ term_d[63];
            lnh_q <= signed'(LnTab[hum]);
            kick_q <= 1'b0;
          end
          if (kick_q) begin
            neg_q <= term_n[63] ^ term_d[63];
            lnh_q <= signed'(LnTab[hum]);
            if (hum == 8'd0 || tden == 17'sd0) valid_q <= 1'b0;
          end
          if (rsp.done) st_q <= StAlpha;
        end
        StAlpha: begin
          alpha_q <= alpha_d;
          st_q <= StDew;
          kick_q <= 1'b1;
        end
        StDew: begin
          if (kick_q) begin
            neg_q <= dew_n[63] ^ den_s[63];
            if (den_s == 64'sd0) valid_q <= 1'b0;
          end
          if (rsp.done) begin
            if (side_q) de_q <= dsat;
            else di_q <= dsat;
            st_q <= StNext;
          end
        end
        StNext: begin
          if (side_q) begin
            st_q <= StDone;
          end else begin
            side_q <= 1'b1;
            st_q <= StTerm;
            kick_q <= 1'b1;
          end
        end
        StDone: begin
          if (valid_q) begin
            verd_q <= (18'(signed'(di_q)) > 18'(signed'(de_q)) + signed'(18'(margin_i)))
                      ? VerdOpen : VerdClose;
          end else begin
            verd_q <= VerdNone;
            di_q <= '0;
            de_q <= '0;
          end
          done_q <= 1'b1;
          st_q <= StIdle;
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  assign done_o = done_q;
  assign verdict_o = verd_q;
  assign dew_in_o = di_q;
  assign dew_out_o = de_q;
  assign busy_o = (st_q != StIdle);
endmodule

[rtl/dew_point_vent_decision_core.sv]
// dew point vent decision core: an accepted evaluate beat starts four 64-step serial divisions
// in one shared divider plus sequencing; its result goes to an output register
// byte and tick beats one per cycle; input stalls while evaluating and while a result waits
// evaluate beats do not overlap; result held in an output register until taken
// asynchronous active-low reset: registers at defaults, readings zero, ages stale
// depends on dpvd_pkg, dpvd_sensor, dpvd_dew, dpvd_sdiv
module dew_point_vent_decision_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [63:0] s_tdata_i,   // sender_mac[47:0], payload_byte[55:48], pad
  input  logic [1:0]  s_tuser_i,   // mode
  input  logic        s_tlast_i,   // last_byte
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [31:0] m_tdata_o,   // dew_inside[15:0], dew_outside[31:16]
  output logic [1:0]  m_tuser_o,   // verdict
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import dpvd_pkg::*;

  logic [MacW-1:0] mac_in_q, mac_out_q;
  logic [AgeW-1:0] tmo_q;
  logic [10:0] margin_q;
  logic [1:0] ridx;
  logic wr, beat, busy, dn, ovalid_q, fresh;
  logic [15:0] tin, tout;
  logic [7:0] hin, hout;
  logic [1:0] verd;
  logic signed [15:0] di, de;

  assign pready = 1'b1;
  assign ridx = paddr[4:3];
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mac_in_q <= '0;
      mac_out_q <= '0;
      tmo_q <= AgeW'(300000);
      margin_q <= 11'd200;
    end else if (wr && paddr[2:0] == 3'd0) begin
      case (ridx)
        RegMacIn: mac_in_q <= pwdata[MacW-1:0];
        RegMacOut: mac_out_q <= pwdata[MacW-1:0];
        RegTimeout: tmo_q <= pwdata[AgeW-1:0];
        RegMargin: margin_q <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      RegMacIn: prdata = 64'(mac_in_q);
      RegMacOut: prdata = 64'(mac_out_q);
      RegTimeout: prdata = 64'(tmo_q);
      RegMargin: prdata = 64'(margin_q);
      default: prdata = '0;
    endcase
  end

  assign s_tready_o = !busy && !ovalid_q && !dn;
  assign beat = s_tvalid_i && s_tready_o;

  dpvd_sensor u_sensor (
    .clk_i(clk_i), .rst_ni(rst_ni), .beat_i(beat), .mode_i(s_tuser_i),
    .mac_i(s_tdata_i[47:0]), .byte_i(s_tdata_i[55:48]), .last_i(s_tlast_i),
    .mac_in_i(mac_in_q), .mac_out_i(mac_out_q), .timeout_i(tmo_q),
    .temp_in_o(tin), .hum_in_o(hin), .temp_out_o(tout), .hum_out_o(hout),
    .fresh_o(fresh)
  );

  dpvd_dew u_dew (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(beat && s_tuser_i == ModeEval),
    .temp_in_i(tin), .hum_in_i(hin), .temp_out_i(tout), .hum_out_i(hout),
    .fresh_i(fresh), .margin_i(margin_q), .done_o(dn), .verdict_o(verd),
    .dew_in_o(di), .dew_out_o(de), .busy_o(busy)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ovalid_q <= 1'b0;
    else if (dn) ovalid_q <= 1'b1;
    else if (m_tready_i) ovalid_q <= 1'b0;
  end

  assign m_tvalid_o = ovalid_q;
  assign m_tdata_o = {de, di};
  assign m_tuser_o = verd;

  a_ready_low_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !s_tready_o) else $error("ready while busy");
  a_done_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dn |=> !dn) else $error("double done");
  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && m_tuser_o == VerdNone) |-> (m_tdata_o == 32'd0))
    else $error("no-data result carries dew values");
endmodule
